[sv/stok_pkg.sv]
// Shared types, character codes and keyword tables for the source tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KIND_BITS         = 6;
    localparam int TQ_DEPTH          = 4;
    localparam int KW_COUNT          = 9;
    localparam int KW_MAX_LEN        = 5;
    localparam logic [2:0] KW_POS_NONE = 3'd7;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    typedef enum logic [KIND_BITS-1:0] {
        TK_END        = 6'd0,
        TK_INT        = 6'd1,
        TK_DEC        = 6'd2,
        TK_STRING     = 6'd3,
        TK_IDENT      = 6'd4,
        TK_KW_BOOL    = 6'd5,
        TK_KW_FALSE   = 6'd6,
        TK_KW_I32     = 6'd7,
        TK_KW_IF      = 6'd8,
        TK_KW_NULL    = 6'd9,
        TK_KW_PRINT   = 6'd10,
        TK_KW_STR     = 6'd11,
        TK_KW_TRUE    = 6'd12,
        TK_KW_WHILE   = 6'd13,
        TK_BANG       = 6'd14,
        TK_NE         = 6'd15,
        TK_PLUS       = 6'd16,
        TK_MINUS      = 6'd17,
        TK_STAR       = 6'd18,
        TK_SLASH      = 6'd19,
        TK_ASSIGN     = 6'd20,
        TK_EQ         = 6'd21,
        TK_LPAREN     = 6'd22,
        TK_RPAREN     = 6'd23,
        TK_LBRACE     = 6'd24,
        TK_RBRACE     = 6'd25,
        TK_SEMI       = 6'd26,
        TK_GT         = 6'd27,
        TK_GE         = 6'd28,
        TK_LT         = 6'd29,
        TK_LE         = 6'd30,
        TK_AND        = 6'd31,
        TK_OR         = 6'd32,
        TK_ERR_CHAR   = 6'd33,
        TK_ERR_STRING = 6'd34
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_INTDOT, M_FRAC, M_IDENT, M_STRING, M_COMMENT,
        M_BANG, M_EQ, M_GT, M_LT, M_AMP, M_PIPE, M_SLASH, M_SKIP
    } mode_t;

    typedef struct packed {
        logic first;
        logic second;
    } emit_ctrl_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_EQUAL  = "=";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_AMP    = "&";
    localparam logic [7:0] CH_PIPE   = "|";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_DOT    = ".";

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"b", "o", "o", "l", CH_NUL},
        '{"f", "a", "l", "s", "e"},
        '{"i", "3", "2", CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL},
        '{"n", "u", "l", "l", CH_NUL},
        '{"p", "r", "i", "n", "t"},
        '{"s", "t", "r", CH_NUL, CH_NUL},
        '{"t", "r", "u", "e", CH_NUL},
        '{"w", "h", "i", "l", "e"}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // pos is the character index, KW_POS_NONE once past every keyword
    function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cands,
                                                      input logic [2:0] pos,
                                                      input logic [7:0] c);
        logic [KW_COUNT-1:0] res;
        res = cands;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= KW_LEN[k])
                res[k] = 1'b0;
            else if (KW_TEXT[k][pos] != c)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    function automatic kind_t ident_kind(input logic [KW_COUNT-1:0] cands,
                                         input logic [2:0] len);
        kind_t res;
        res = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cands[k] && (len == KW_LEN[k]))
                res = kind_t'(KIND_BITS'(int'(TK_KW_BOOL) + k));
        end
        return res;
    endfunction

endpackage

[sv/stok_scanner.sv]
// Byte input register, scan state and token generation for up to two tokens per byte.
`timescale 1ns / 1ps

module stok_scanner #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     source_byte,
    input  logic                           queue_space,
    output stok_pkg::emit_ctrl_t           emit,
    output stok_pkg::kind_t                kind0,
    output logic [POSITION_BITS-1:0]       start0,
    output logic [POSITION_BITS-1:0]       len0,
    output stok_pkg::kind_t                kind1,
    output logic [POSITION_BITS-1:0]       start1,
    output logic [POSITION_BITS-1:0]       len1,
    output logic [POSITION_BITS-1:0]       line
);
    import stok_pkg::*;

    localparam logic [POSITION_BITS-1:0] ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] TWO = POSITION_BITS'(2);

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
        return (&x) ? x : x + ONE;
    endfunction

    logic                     byte_full_reg, byte_full_next;
    logic [7:0]               byte_reg;
    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] offset_reg, offset_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [POSITION_BITS-1:0] plen_reg, plen_next;
    logic [KW_COUNT-1:0]      kwc_reg, kwc_next;

    logic       step;
    logic [7:0] c;
    logic       c_digit, c_alpha;
    logic       redo;
    logic [2:0] pos_small;

    assign step     = byte_full_reg && queue_space;
    assign in_ready = !byte_full_reg || queue_space;
    assign c        = byte_reg;
    assign c_digit  = is_digit(c);
    assign c_alpha  = is_alpha(c);
    assign pos_small = (plen_reg <= POSITION_BITS'(KW_MAX_LEN)) ? plen_reg[2:0] : KW_POS_NONE;
    assign line     = line_reg;

    always_comb
    begin
        unique case (mode_reg)
            M_IDLE:    redo = 1'b1;
            M_INT:     redo = !c_digit && (c != CH_DOT);
            M_FRAC:    redo = !c_digit;
            M_IDENT:   redo = !(c_digit || c_alpha);
            M_COMMENT: redo = (c == CH_LF) || (c == CH_NUL);
            M_BANG, M_EQ, M_GT, M_LT: redo = (c != CH_EQUAL);
            M_SLASH:   redo = (c != CH_SLASH);
            M_INTDOT, M_STRING, M_AMP, M_PIPE, M_SKIP: redo = 1'b0;
            default:   redo = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        logic restart;
        restart     = 1'b0;
        mode_next   = mode_reg;
        line_next   = line_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        kwc_next    = kwc_reg;

        unique case (mode_reg)
            M_INT:
                if (c_digit) plen_next = sat_inc(plen_reg);
                else if (c == CH_DOT) mode_next = M_INTDOT;
                else mode_next = M_IDLE;
            M_INTDOT:
                if (c_digit)
                begin
                    plen_next = sat_inc(sat_inc(plen_reg));
                    mode_next = M_FRAC;
                end
                else
                begin
                    mode_next = M_SKIP;
                    restart   = (c == CH_NUL);
                end
            M_FRAC:
                if (c_digit) plen_next = sat_inc(plen_reg);
                else mode_next = M_IDLE;
            M_IDENT:
                if (c_digit || c_alpha)
                begin
                    kwc_next  = kw_filter(kwc_reg, pos_small, c);
                    plen_next = sat_inc(plen_reg);
                end
                else mode_next = M_IDLE;
            M_STRING:
                if (c == CH_NUL) restart = 1'b1;
                else if (c == CH_QUOTE) mode_next = M_IDLE;
                else
                begin
                    if (c == CH_LF) line_next = sat_inc(line_reg);
                    plen_next = sat_inc(plen_reg);
                end
            M_COMMENT:
                if (redo) mode_next = M_IDLE;
            M_BANG, M_EQ, M_GT, M_LT:
                mode_next = M_IDLE;
            M_AMP, M_PIPE:
                if (c == ((mode_reg == M_AMP) ? CH_AMP : CH_PIPE)) mode_next = M_IDLE;
                else
                begin
                    mode_next = M_SKIP;
                    restart   = (c == CH_NUL);
                end
            M_SLASH:
                if (c == CH_SLASH) mode_next = M_COMMENT;
                else mode_next = M_IDLE;
            M_SKIP:
                restart = (c == CH_NUL);
            M_IDLE: ;
            default: ;
        endcase

        if (redo)
        begin
            mode_next   = M_IDLE;
            pstart_next = offset_reg;
            unique case (c)
                CH_SPACE, CH_CR, CH_TAB: ;
                CH_LF:     line_next = sat_inc(line_reg);
                CH_QUOTE:
                begin
                    mode_next   = M_STRING;
                    pstart_next = sat_inc(offset_reg);
                    plen_next   = '0;
                end
                CH_BANG:   mode_next = M_BANG;
                CH_EQUAL:  mode_next = M_EQ;
                CH_GT:     mode_next = M_GT;
                CH_LT:     mode_next = M_LT;
                CH_AMP:    mode_next = M_AMP;
                CH_PIPE:   mode_next = M_PIPE;
                CH_SLASH:  mode_next = M_SLASH;
                CH_PLUS, CH_MINUS, CH_STAR, CH_LPAREN, CH_RPAREN,
                CH_LBRACE, CH_RBRACE, CH_SEMI: ;
                CH_NUL:    restart = 1'b1;
                default:
                    if (c_digit)
                    begin
                        mode_next = M_INT;
                        plen_next = ONE;
                    end
                    else if (c_alpha)
                    begin
                        mode_next = M_IDENT;
                        plen_next = ONE;
                        kwc_next  = kw_filter(KW_ALL, 3'd0, c);
                    end
                    else mode_next = M_SKIP;
            endcase
        end

        if (restart)
        begin
            mode_next   = M_IDLE;
            offset_next = '0;
            line_next   = ONE;
            pstart_next = '0;
            plen_next   = '0;
            kwc_next    = KW_ALL;
        end
        else offset_next = sat_inc(offset_reg);
    end

    // token outputs
    always_comb
    begin
        logic  e0, e1, r_emit;
        kind_t r_kind, one_kind;
        e0 = 1'b0;
        e1 = 1'b0;
        r_emit = 1'b0;
        r_kind = TK_ERR_CHAR;
        kind0  = TK_END;
        start0 = pstart_reg;
        len0   = plen_reg;
        kind1  = TK_ERR_CHAR;
        start1 = '0;
        len1   = ONE;

        unique case (mode_reg)
            M_BANG:  one_kind = TK_BANG;
            M_EQ:    one_kind = TK_ASSIGN;
            M_GT:    one_kind = TK_GT;
            default: one_kind = TK_LT;
        endcase

        unique case (mode_reg)
            M_INT:
                if (redo)
                begin
                    e0 = 1'b1;
                    kind0 = TK_INT;
                end
            M_INTDOT:
                if (!c_digit)
                begin
                    e0 = 1'b1;
                    e1 = 1'b1;
                    kind0  = TK_INT;
                    start1 = (offset_reg != '0) ? offset_reg - ONE : '0;
                end
            M_FRAC:
                if (redo)
                begin
                    e0 = 1'b1;
                    kind0 = TK_DEC;
                end
            M_IDENT:
                if (redo)
                begin
                    e0 = 1'b1;
                    kind0 = ident_kind(kwc_reg, pos_small);
                end
            M_STRING:
                if (c == CH_NUL)
                begin
                    e0 = 1'b1;
                    kind0 = TK_ERR_STRING;
                end
                else if (c == CH_QUOTE)
                begin
                    e0 = 1'b1;
                    kind0 = TK_STRING;
                end
            M_BANG, M_EQ, M_GT, M_LT:
            begin
                e0 = 1'b1;
                if (c == CH_EQUAL)
                begin
                    kind0 = kind_t'(KIND_BITS'(int'(one_kind) + 1));
                    len0  = TWO;
                end
                else
                begin
                    kind0 = one_kind;
                    len0  = ONE;
                end
            end
            M_AMP, M_PIPE:
            begin
                e0 = 1'b1;
                if (c == ((mode_reg == M_AMP) ? CH_AMP : CH_PIPE))
                begin
                    kind0 = (mode_reg == M_AMP) ? TK_AND : TK_OR;
                    len0  = TWO;
                end
                else
                begin
                    kind0 = TK_ERR_CHAR;
                    len0  = ONE;
                end
            end
            M_SLASH:
                if (redo)
                begin
                    e0 = 1'b1;
                    kind0 = TK_SLASH;
                    len0  = ONE;
                end
            M_IDLE, M_COMMENT, M_SKIP: ;
            default: ;
        endcase

        if (redo)
        begin
            unique case (c)
                CH_PLUS:   begin r_emit = 1'b1; r_kind = TK_PLUS;   end
                CH_MINUS:  begin r_emit = 1'b1; r_kind = TK_MINUS;  end
                CH_STAR:   begin r_emit = 1'b1; r_kind = TK_STAR;   end
                CH_LPAREN: begin r_emit = 1'b1; r_kind = TK_LPAREN; end
                CH_RPAREN: begin r_emit = 1'b1; r_kind = TK_RPAREN; end
                CH_LBRACE: begin r_emit = 1'b1; r_kind = TK_LBRACE; end
                CH_RBRACE: begin r_emit = 1'b1; r_kind = TK_RBRACE; end
                CH_SEMI:   begin r_emit = 1'b1; r_kind = TK_SEMI;   end
                CH_NUL:    begin r_emit = 1'b1; r_kind = TK_END;    end
                CH_SPACE, CH_CR, CH_TAB, CH_LF, CH_QUOTE, CH_BANG, CH_EQUAL,
                CH_GT, CH_LT, CH_AMP, CH_PIPE, CH_SLASH: ;
                default:
                    if (!c_digit && !c_alpha)
                    begin
                        r_emit = 1'b1;
                        r_kind = TK_ERR_CHAR;
                    end
            endcase
        end

        if (r_emit)
        begin
            if (e0)
            begin
                e1 = 1'b1;
                kind1  = r_kind;
                start1 = offset_reg;
                len1   = ONE;
            end
            else
            begin
                e0 = 1'b1;
                kind0  = r_kind;
                start0 = offset_reg;
                len0   = ONE;
            end
        end

        emit.first  = step && e0;
        emit.second = step && e1;
    end

    always_comb
    begin
        byte_full_next = byte_full_reg;
        if (in_valid && in_ready) byte_full_next = 1'b1;
        else if (step) byte_full_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) byte_reg <= source_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_full_reg <= 1'b0;
            mode_reg      <= M_IDLE;
            offset_reg    <= '0;
            line_reg      <= ONE;
            pstart_reg    <= '0;
            plen_reg      <= '0;
            kwc_reg       <= KW_ALL;
        end
        else
        begin
            byte_full_reg <= byte_full_next;
            if (step)
            begin
                mode_reg   <= mode_next;
                offset_reg <= offset_next;
                line_reg   <= line_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                kwc_reg    <= kwc_next;
            end
        end
    end

endmodule

[sv/stok_token_fifo.sv]
// Small token queue taking up to two tokens per cycle and releasing one per transfer.
`timescale 1ns / 1ps

module stok_token_fifo #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stok_pkg::emit_ctrl_t                emit,
    input  stok_pkg::kind_t                     kind0,
    input  logic [POSITION_BITS-1:0]            start0,
    input  logic [POSITION_BITS-1:0]            len0,
    input  stok_pkg::kind_t                     kind1,
    input  logic [POSITION_BITS-1:0]            start1,
    input  logic [POSITION_BITS-1:0]            len1,
    input  logic [POSITION_BITS-1:0]            line,
    output logic                                queue_space,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [stok_pkg::KIND_BITS-1:0]      token_kind,
    output logic [POSITION_BITS-1:0]            token_start,
    output logic [POSITION_BITS-1:0]            token_length,
    output logic [POSITION_BITS-1:0]            token_line,
    output logic                                last_of_run
);
    import stok_pkg::*;

    localparam int PTR_BITS = $clog2(TQ_DEPTH);
    localparam int CNT_BITS = $clog2(TQ_DEPTH + 1);

    logic [KIND_BITS-1:0]     kind_q  [TQ_DEPTH];
    logic [POSITION_BITS-1:0] start_q [TQ_DEPTH];
    logic [POSITION_BITS-1:0] len_q   [TQ_DEPTH];
    logic [POSITION_BITS-1:0] line_q  [TQ_DEPTH];
    logic                     last_q  [TQ_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] wr_ptr_plus1;
    logic                pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign queue_space  = (count_reg <= CNT_BITS'(TQ_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    assign token_kind   = kind_q[rd_ptr_reg];
    assign token_start  = start_q[rd_ptr_reg];
    assign token_length = len_q[rd_ptr_reg];
    assign token_line   = line_q[rd_ptr_reg];
    assign last_of_run  = last_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(emit.first) + PTR_BITS'(emit.second);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(emit.first) + CNT_BITS'(emit.second)
                      - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (emit.first)
        begin
            kind_q[wr_ptr_reg]  <= kind0;
            start_q[wr_ptr_reg] <= start0;
            len_q[wr_ptr_reg]   <= len0;
            line_q[wr_ptr_reg]  <= line;
            last_q[wr_ptr_reg]  <= !emit.second;
        end
        if (emit.second)
        begin
            kind_q[wr_ptr_plus1]  <= kind1;
            start_q[wr_ptr_plus1] <= start1;
            len_q[wr_ptr_plus1]   <= len1;
            line_q[wr_ptr_plus1]  <= line;
            last_q[wr_ptr_plus1]  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/source_tokenizer_top.sv]
// Top level of the streaming source tokenizer.
// Each byte waits in the scanner's byte register; tokens it completes enter the token queue.
// Throughput: one byte per cycle while the queue has room; tokens leave one per transfer.
// Input stalls while a byte is held and the four-entry queue has under two free entries.
// Reset: asynchronous active-low; scanner idle, offset 0, line 1, queue empty.
`timescale 1ns / 1ps

module source_tokenizer_top #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      source_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [stok_pkg::KIND_BITS-1:0]  token_kind,
    output logic [POSITION_BITS-1:0]        token_start,
    output logic [POSITION_BITS-1:0]        token_length,
    output logic [POSITION_BITS-1:0]        token_line,
    output logic                            last_of_run
);
    import stok_pkg::*;

    emit_ctrl_t               emit;
    kind_t                    kind0, kind1;
    logic [POSITION_BITS-1:0] start0, start1, len0, len1, line;
    logic                     queue_space;

    stok_scanner #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scanner (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .source_byte (source_byte),
        .queue_space (queue_space),
        .emit        (emit),
        .kind0       (kind0),
        .start0      (start0),
        .len0        (len0),
        .kind1       (kind1),
        .start1      (start1),
        .len1        (len1),
        .line        (line)
    );

    stok_token_fifo #(
        .POSITION_BITS(POSITION_BITS)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .kind0        (kind0),
        .start0       (start0),
        .len0         (len0),
        .kind1        (kind1),
        .start1       (start1),
        .len1         (len1),
        .line         (line),
        .queue_space  (queue_space),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

endmodule

[sv/stok_checker.sv]
// Port-level assertions for the source tokenizer, bound to the top level.
`timescale 1ns / 1ps

module stok_checker #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [stok_pkg::KIND_BITS-1:0]  token_kind,
    input logic [POSITION_BITS-1:0]        token_start,
    input logic [POSITION_BITS-1:0]        token_length,
    input logic [POSITION_BITS-1:0]        token_line,
    input logic                            last_of_run
);
    import stok_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(token_start) && $stable(token_length) && $stable(last_of_run))
        else $error("token changed while stalled");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_line != '0)
        else $error("line count reached zero");

    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == TK_END) |-> (token_length == POSITION_BITS'(1)) && last_of_run)
        else $error("end token malformed");

    a_pair_ops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((token_kind == TK_NE) || (token_kind == TK_EQ) || (token_kind == TK_GE)
            || (token_kind == TK_LE) || (token_kind == TK_AND) || (token_kind == TK_OR))
        |-> token_length == POSITION_BITS'(2))
        else $error("two-character operator with wrong length");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= TK_ERR_STRING)
        else $error("token kind out of range");

endmodule

bind source_tokenizer_top stok_checker #(
    .POSITION_BITS(POSITION_BITS)
) u_stok_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_line   (token_line),
    .last_of_run  (last_of_run)
);

[tb/tb_source_tokenizer_top.sv]
// Self-checking testbench for the source tokenizer: directed, random and full-rate text.
`timescale 1ns / 1ps

module tb_source_tokenizer_top;
    import stok_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  source_byte;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        last_of_run;

    source_tokenizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .last_of_run  (last_of_run)
    );

    always #2 clk = ~clk;

    // predicted scanner state
    mode_t       lex_mode;
    logic [15:0] cur_offset;
    logic [15:0] cur_line;
    logic [15:0] tok_begin;
    logic [15:0] tok_len;
    logic [8:0]  kw_live;

    token_t pending_tokens[$];
    token_t step_toks[2];
    int     step_n;

    logic [7:0] text_q[$];

    string kw_words[9] = '{"bool", "false", "i32", "if", "null",
                           "print", "str", "true", "while"};
    string op_words[19] = '{"!", "!=", "+", "-", "*", "/", "=", "==", "(", ")",
                            "{", "}", ";", ">", ">=", "<", "<=", "&&", "||"};

    int  err_count;
    int  bytes_sent;
    int  tokens_seen;
    int  stall_left;
    bit  gaps_on;
    bit  stalls_on;

    function automatic logic [15:0] sat_inc(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [8:0] kw_narrow(input logic [8:0] cands, input logic [15:0] pos,
                                             input logic [7:0] c);
        logic [8:0] res;
        res = cands;
        for (int k = 0; k < 9; k++)
        begin
            if (int'(pos) >= kw_words[k].len())
                res[k] = 1'b0;
            else if (kw_words[k][int'(pos)] != c)
                res[k] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [5:0] word_kind();
        logic [5:0] res;
        res = TK_IDENT;
        for (int k = 8; k >= 0; k--)
        begin
            if (kw_live[k] && (int'(tok_len) == kw_words[k].len()))
                res = TK_KW_BOOL + 6'(k);
        end
        return res;
    endfunction

    function automatic void reset_model();
        lex_mode   = M_IDLE;
        cur_offset = 16'd0;
        cur_line   = 16'd1;
        tok_begin  = 16'd0;
        tok_len    = 16'd0;
        kw_live    = '1;
    endfunction

    function automatic void emit_tok(input logic [5:0] kind, input logic [15:0] start,
                                     input logic [15:0] len);
        step_toks[step_n] = '{kind, start, len, cur_line, 1'b0};
        step_n++;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c);
        logic [15:0] here;
        logic [5:0]  one;
        bit          redo;
        bit          restart;
        here    = cur_offset;
        redo    = 1'b1;
        restart = 1'b0;
        step_n  = 0;
        case (lex_mode)
            M_INT:
            begin
                if (is_num(c))
                begin
                    tok_len = sat_inc(tok_len);
                    redo = 1'b0;
                end
                else if (c == CH_DOT)
                begin
                    lex_mode = M_INTDOT;
                    redo = 1'b0;
                end
                else
                begin
                    emit_tok(TK_INT, tok_begin, tok_len);
                    lex_mode = M_IDLE;
                end
            end
            M_INTDOT:
            begin
                redo = 1'b0;
                if (is_num(c))
                begin
                    tok_len = sat_inc(sat_inc(tok_len));
                    lex_mode = M_FRAC;
                end
                else
                begin
                    emit_tok(TK_INT, tok_begin, tok_len);
                    emit_tok(TK_ERR_CHAR, (here != 16'd0) ? here - 16'd1 : 16'd0, 16'd1);
                    lex_mode = M_SKIP;
                    if (c == CH_NUL)
                        restart = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (is_num(c))
                begin
                    tok_len = sat_inc(tok_len);
                    redo = 1'b0;
                end
                else
                begin
                    emit_tok(TK_DEC, tok_begin, tok_len);
                    lex_mode = M_IDLE;
                end
            end
            M_IDENT:
            begin
                if (is_num(c) || is_letter(c))
                begin
                    kw_live = kw_narrow(kw_live, tok_len, c);
                    tok_len = sat_inc(tok_len);
                    redo = 1'b0;
                end
                else
                begin
                    emit_tok(word_kind(), tok_begin, tok_len);
                    lex_mode = M_IDLE;
                end
            end
            M_STRING:
            begin
                redo = 1'b0;
                if (c == CH_NUL)
                begin
                    emit_tok(TK_ERR_STRING, tok_begin, tok_len);
                    restart = 1'b1;
                end
                else if (c == CH_QUOTE)
                begin
                    emit_tok(TK_STRING, tok_begin, tok_len);
                    lex_mode = M_IDLE;
                end
                else
                begin
                    if (c == CH_LF)
                        cur_line = sat_inc(cur_line);
                    tok_len = sat_inc(tok_len);
                end
            end
            M_COMMENT:
            begin
                if (c == CH_LF || c == CH_NUL)
                    lex_mode = M_IDLE;
                else
                    redo = 1'b0;
            end
            M_BANG, M_EQ, M_GT, M_LT:
            begin
                one = (lex_mode == M_BANG) ? TK_BANG : (lex_mode == M_EQ) ? TK_ASSIGN :
                      (lex_mode == M_GT) ? TK_GT : TK_LT;
                if (c == CH_EQUAL)
                begin
                    emit_tok(one + 6'd1, tok_begin, 16'd2);
                    redo = 1'b0;
                end
                else
                    emit_tok(one, tok_begin, 16'd1);
                lex_mode = M_IDLE;
            end
            M_AMP, M_PIPE:
            begin
                redo = 1'b0;
                if (c == ((lex_mode == M_AMP) ? CH_AMP : CH_PIPE))
                begin
                    emit_tok((lex_mode == M_AMP) ? TK_AND : TK_OR, tok_begin, 16'd2);
                    lex_mode = M_IDLE;
                end
                else
                begin
                    emit_tok(TK_ERR_CHAR, tok_begin, 16'd1);
                    lex_mode = M_SKIP;
                    if (c == CH_NUL)
                        restart = 1'b1;
                end
            end
            M_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    lex_mode = M_COMMENT;
                    redo = 1'b0;
                end
                else
                begin
                    emit_tok(TK_SLASH, tok_begin, 16'd1);
                    lex_mode = M_IDLE;
                end
            end
            M_SKIP:
            begin
                redo = 1'b0;
                if (c == CH_NUL)
                    restart = 1'b1;
            end
            default: ;
        endcase

        if (redo)
        begin
            lex_mode  = M_IDLE;
            tok_begin = here;
            case (c)
                CH_SPACE, CH_CR, CH_TAB: ;
                CH_LF:     cur_line = sat_inc(cur_line);
                CH_QUOTE:
                begin
                    lex_mode  = M_STRING;
                    tok_begin = sat_inc(here);
                    tok_len   = 16'd0;
                end
                CH_BANG:   lex_mode = M_BANG;
                CH_EQUAL:  lex_mode = M_EQ;
                CH_GT:     lex_mode = M_GT;
                CH_LT:     lex_mode = M_LT;
                CH_AMP:    lex_mode = M_AMP;
                CH_PIPE:   lex_mode = M_PIPE;
                CH_SLASH:  lex_mode = M_SLASH;
                CH_PLUS:   emit_tok(TK_PLUS, here, 16'd1);
                CH_MINUS:  emit_tok(TK_MINUS, here, 16'd1);
                CH_STAR:   emit_tok(TK_STAR, here, 16'd1);
                CH_LPAREN: emit_tok(TK_LPAREN, here, 16'd1);
                CH_RPAREN: emit_tok(TK_RPAREN, here, 16'd1);
                CH_LBRACE: emit_tok(TK_LBRACE, here, 16'd1);
                CH_RBRACE: emit_tok(TK_RBRACE, here, 16'd1);
                CH_SEMI:   emit_tok(TK_SEMI, here, 16'd1);
                CH_NUL:
                begin
                    emit_tok(TK_END, here, 16'd1);
                    restart = 1'b1;
                end
                default:
                begin
                    if (is_num(c))
                    begin
                        lex_mode = M_INT;
                        tok_len  = 16'd1;
                    end
                    else if (is_letter(c))
                    begin
                        lex_mode = M_IDENT;
                        tok_len  = 16'd1;
                        kw_live  = kw_narrow('1, 16'd0, c);
                    end
                    else
                    begin
                        emit_tok(TK_ERR_CHAR, here, 16'd1);
                        lex_mode = M_SKIP;
                    end
                end
            endcase
        end

        if (restart)
            reset_model();
        else
            cur_offset = sat_inc(cur_offset);

        for (int i = 0; i < step_n; i++)
        begin
            step_toks[i].last = (i == step_n - 1);
            pending_tokens.push_back(step_toks[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // one source byte over the input channel, with an optional idle burst first
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        source_byte <= c;
        do
            @(posedge clk);
        while (!in_ready);
        predict_tokens(c);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i]);
        text_q.delete();
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range("0", "9"));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
    endfunction

    // any non-zero byte except the quote; mostly printable
    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
        if (c == CH_QUOTE)
            c = "q";
        return c;
    endfunction

    task automatic maybe_restart();
        if ($urandom_range(0, 4) != 0)
            text_q.push_back(CH_NUL);
    endtask

    // one random phrase of source text, mostly well formed
    task automatic make_phrase();
        string      s;
        int         variant;
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1:
            begin
                s = kw_words[$urandom_range(0, 8)];
                variant = $urandom_range(0, 5);
                if (variant == 0)
                    s = s.substr(0, s.len() - 2);
                else if (variant == 2)
                    s[0] = s[0] - 8'd32;
                push_str(s);
                if (variant == 1)
                    text_q.push_back(rand_alnum());
            end
            2, 3:
            begin
                text_q.push_back(rand_letter());
                repeat ($urandom_range(0, 7)) text_q.push_back(rand_alnum());
            end
            4, 5:
                repeat ($urandom_range(1, 5)) text_q.push_back(rand_digit());
            6:
            begin
                repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
                text_q.push_back(CH_DOT);
                repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
            end
            7:
            begin
                text_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 8))
                    text_q.push_back(($urandom_range(0, 5) == 0) ? CH_LF : rand_text_char());
                text_q.push_back(CH_QUOTE);
            end
            8:
            begin
                push_str("//");
                repeat ($urandom_range(0, 8))
                begin
                    c = rand_text_char();
                    text_q.push_back((c == CH_LF) ? CH_SPACE : c);
                end
                text_q.push_back(($urandom_range(0, 5) == 0) ? CH_NUL : CH_LF);
            end
            9, 10, 11, 12:
                push_str(op_words[$urandom_range(0, 18)]);
            13:
            begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(CH_TAB);
                    1:       text_q.push_back(CH_CR);
                    2:       text_q.push_back(CH_LF);
                    default: text_q.push_back(CH_SPACE);
                endcase
            end
            14:
                text_q.push_back(CH_NUL);
            15:
            begin
                text_q.push_back(8'($urandom_range(1, 255)));
                maybe_restart();
            end
            16:
            begin
                text_q.push_back($urandom_range(0, 1) ? CH_AMP : CH_PIPE);
                text_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : rand_text_char());
                maybe_restart();
            end
            17:
            begin
                repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
                text_q.push_back(CH_DOT);
                text_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : rand_letter());
                maybe_restart();
            end
            default:
            begin
                text_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6)) text_q.push_back(rand_text_char());
                text_q.push_back(CH_NUL);
            end
        endcase
        if ($urandom_range(0, 9) < 6)
            text_q.push_back(($urandom_range(0, 4) == 0) ? CH_LF : CH_SPACE);
    endtask

    task automatic test_basic_tokens();
        push_str("while i32 whilex>=7.25//c\n");
        text_q.push_back(CH_NUL);
        send_text();
        end_stream();
        wait_drained();
    endtask

    task automatic test_error_paths();
        push_str("3.x?");
        text_q.push_back(CH_NUL);
        push_str("a&b");
        text_q.push_back(CH_NUL);
        push_str("c|");
        text_q.push_back(CH_NUL);
        push_str("\"ab");
        text_q.push_back(CH_NUL);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_NUL);
        text_q.push_back(8'h0B);
        text_q.push_back(CH_NUL);
        push_str("5.");
        text_q.push_back(CH_NUL);
        send_text();
        end_stream();
        wait_drained();
    endtask

    task automatic test_random_text();
        while (bytes_sent < 1200)
        begin
            make_phrase();
            send_text();
        end
        end_stream();
        wait_drained();
    endtask

    task automatic test_back_to_back();
        int first;
        first = bytes_sent;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        while (bytes_sent - first < 300)
        begin
            make_phrase();
            send_text();
        end
        text_q.push_back(CH_NUL);
        send_text();
        end_stream();
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            tokens_seen++;
            if (pending_tokens.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                          token_kind, token_start));
            else
            begin
                want = pending_tokens.pop_front();
                if (token_kind !== want.kind || token_start !== want.start ||
                    token_length !== want.len || token_line !== want.line ||
                    last_of_run !== want.last)
                    report_mismatch($sformatf(
                        "got k%0d s%0d l%0d ln%0d e%0b, want k%0d s%0d l%0d ln%0d e%0b",
                        token_kind, token_start, token_length, token_line, last_of_run,
                        want.kind, want.start, want.len, want.line, want.last));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        source_byte = 8'd0;
        out_ready   = 1'b0;
        err_count   = 0;
        bytes_sent  = 0;
        tokens_seen = 0;
        stall_left  = 0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        reset_model();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_basic_tokens();
        test_error_paths();
        test_random_text();
        test_back_to_back();

        $display("Sent %0d source bytes and checked %0d tokens, with %0d mismatches.",
                 bytes_sent, tokens_seen, err_count);
        $display("Covered directed tokens, error paths, random text with idling and a full-rate tail.");
        if (err_count == 0 && pending_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
sv/stok_pkg.sv
sv/stok_scanner.sv
sv/stok_token_fifo.sv
sv/source_tokenizer_top.sv
sv/stok_checker.sv
tb/tb_source_tokenizer_top.sv
